// File: design/ps2kc_pkg.sv
`timescale 1ns / 1ps

package ps2kc_pkg;

    // host and device access kinds
    localparam logic [2:0] FUNC_READ_DATA   = 3'd0;
    localparam logic [2:0] FUNC_READ_STATUS = 3'd1;
    localparam logic [2:0] FUNC_WRITE_DATA  = 3'd2;
    localparam logic [2:0] FUNC_WRITE_CMD   = 3'd3;
    localparam logic [2:0] FUNC_DEVICE      = 3'd4;

    // data port routing mode
    localparam logic [1:0] MODE_KBD = 2'd0;
    localparam logic [1:0] MODE_MOU = 2'd1;
    localparam logic [1:0] MODE_COM = 2'd2;

    // command groups, selected by the top three bits of the command byte
    localparam logic [2:0] GRP_RAM_READ  = 3'd1;
    localparam logic [2:0] GRP_RAM_WRITE = 3'd3;
    localparam logic [2:0] GRP_PORT_LOW  = 3'd4;
    localparam logic [2:0] GRP_TEST      = 3'd5;
    localparam logic [2:0] GRP_PORT      = 3'd6;
    localparam logic [2:0] GRP_PULSE     = 3'd7;

    // individual commands
    localparam logic [7:0] CMD_NONE        = 8'h00;
    localparam logic [7:0] CMD_WRITE_CFG   = 8'h60;
    localparam logic [7:0] CMD_VERSION     = 8'hA1;
    localparam logic [7:0] CMD_PASS_TEST   = 8'hA4;
    localparam logic [7:0] CMD_PASS_ENTER  = 8'hA5;
    localparam logic [7:0] CMD_MOUSE_OFF   = 8'hA7;
    localparam logic [7:0] CMD_MOUSE_ON    = 8'hA8;
    localparam logic [7:0] CMD_MOUSE_TEST  = 8'hA9;
    localparam logic [7:0] CMD_SELF_TEST   = 8'hAA;
    localparam logic [7:0] CMD_KBD_TEST    = 8'hAB;
    localparam logic [7:0] CMD_KBD_OFF     = 8'hAD;
    localparam logic [7:0] CMD_KBD_ON      = 8'hAE;
    localparam logic [7:0] CMD_READ_INPORT = 8'hC0;
    localparam logic [7:0] CMD_POLL_LOW    = 8'hC1;
    localparam logic [7:0] CMD_POLL_HIGH   = 8'hC2;
    localparam logic [7:0] CMD_READ_OUTP   = 8'hD0;
    localparam logic [7:0] CMD_WRITE_OUTP  = 8'hD1;
    localparam logic [7:0] CMD_ECHO_KBD    = 8'hD2;
    localparam logic [7:0] CMD_ECHO_MOUSE  = 8'hD3;
    localparam logic [7:0] CMD_TO_MOUSE    = 8'hD4;
    localparam logic [7:0] CMD_TEST_INPUTS = 8'hE0;
    localparam logic [7:0] CMD_SOFT_RESET  = 8'hFF;

    // constant replies and reset values
    localparam logic [7:0] REPLY_VERSION   = 8'hFF;
    localparam logic [7:0] REPLY_PASS_NONE = 8'hF1;
    localparam logic [7:0] REPLY_SELF_OK   = 8'h55;
    localparam logic [7:0] REPLY_ZERO      = 8'h00;
    localparam logic [7:0] OUT_PORT_RESET  = 8'h02;

    typedef struct packed {
        logic       force_req;
        logic       from_mouse;
        logic [2:0] func;
        logic [7:0] value;
    } ps2kc_item_t;

    // packed so that read_data sits in the lowest bits
    typedef struct packed {
        logic       device_accepted;
        logic       xt_translate;
        logic [7:0] output_port;
        logic       reset_request;
        logic       irq_aux;
        logic       irq_kbd;
        logic [7:0] send_byte;
        logic       send_mouse;
        logic       send_kbd;
        logic       read_valid;
        logic [7:0] read_data;
    } ps2kc_result_t;

endpackage

// File: design/ps2_keyboard_controller.sv
`timescale 1ns / 1ps

// host-side ps/2 keyboard controller, one access per transfer
// slave channel (s_*) carries one access: a data or status port read,
// a data or command port write, or a byte arriving from the keyboard or mouse
// master channel (m_*) returns exactly one result per access: the read byte,
// bytes forwarded to the devices, interrupt and reset pulses, the output
// port, the scan code translation flag and whether a device byte was taken
// the access is held in the access register and its result in the result
// register, which drives m_tvalid; throughput: one access per cycle while
// m_tready stays high; the access register feeds a single pass of decode
// and state update straight into the result register; a stalled master
// side (m_tready low) holds the result; one more access is taken into the
// access register, then s_tready drops until the result is transferred
// reset: status, output buffer and controller ram cleared, no command
// pending, keyboard mode, output port 0x02, input port and translation 0
// a refused device byte (device_accepted 0) must be offered again later

module ps2_keyboard_controller
    import ps2kc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // value
    input  logic [4:0]  s_tuser,   // func[2:0], from_mouse, force_req
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data[7:0], read_valid, send_kbd, send_mouse, send_byte[7:0],
    // irq_kbd, irq_aux, reset_request, output_port[7:0], xt_translate,
    // device_accepted
    output logic [31:0] m_tdata
);

    logic          in_valid_reg;
    ps2kc_item_t   in_item_reg;
    logic          out_valid_reg;
    ps2kc_result_t out_result_reg;
    ps2kc_result_t step_result;
    logic          advance;

    // the held access moves on whenever the result slot is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.value      <= s_tdata;
            in_item_reg.func       <= s_tuser[2:0];
            in_item_reg.from_mouse <= s_tuser[3];
            in_item_reg.force_req  <= s_tuser[4];
        end
    end

    // controller state and per-access decode
    ps2kc_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (in_item_reg),
        .result  (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_result_reg <= step_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_result_reg;

endmodule

// File: design/ps2kc_core.sv
`timescale 1ns / 1ps

module ps2kc_core
    import ps2kc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step_en,
    input  ps2kc_item_t   item,
    output ps2kc_result_t result
);

    logic [7:0] status_reg, status_next;
    logic [7:0] obuf_reg, obuf_next;
    logic [7:0] pend_reg, pend_next;
    logic [1:0] mode_reg, mode_next;
    logic [7:0] outp_reg, outp_next;
    logic [7:0] inp_reg, inp_next;
    logic       xlat_reg, xlat_next;
    logic [7:0] ram_reg [32];

    logic       ram_we;
    logic [4:0] ram_waddr;
    logic [7:0] ram_wdata;
    logic [7:0] cfg_byte;
    logic [7:0] v;

    // status after a byte lands in the output buffer
    function automatic logic [7:0] obuf_status(input logic [7:0] s, input logic mouse);
        obuf_status = (s & 8'hDE) | 8'h01 | (mouse ? 8'h20 : 8'h00);
    endfunction

    assign cfg_byte = ram_reg[0];
    assign v        = item.value;

    always_comb
    begin
        status_next = status_reg;
        obuf_next   = obuf_reg;
        pend_next   = pend_reg;
        mode_next   = mode_reg;
        outp_next   = outp_reg;
        inp_next    = inp_reg;
        xlat_next   = xlat_reg;
        ram_we      = 1'b0;
        ram_waddr   = 5'd0;
        ram_wdata   = v;
        result      = '0;

        unique case (item.func)
            FUNC_READ_DATA:
            begin
                if (status_reg[0])
                begin
                    result.read_data  = obuf_reg;
                    result.read_valid = 1'b1;
                    status_next       = status_reg & 8'hFE;
                end
            end
            FUNC_READ_STATUS:
            begin
                result.read_data  = status_reg | 8'h10;
                result.read_valid = 1'b1;
                status_next       = status_reg & 8'hFD;
            end
            FUNC_WRITE_DATA:
            begin
                status_next = status_reg | 8'h0A;
                unique case (mode_reg)
                    MODE_MOU:
                    begin
                        result.send_mouse = 1'b1;
                        result.send_byte  = v;
                        mode_next         = MODE_KBD;
                    end
                    MODE_COM:
                    begin
                        if (pend_reg == CMD_WRITE_OUTP)
                        begin
                            outp_next            = v;
                            result.reset_request = ~v[0];
                        end
                        else if (pend_reg == CMD_ECHO_KBD)
                        begin
                            obuf_next   = v;
                            status_next = obuf_status(status_reg | 8'h0A, 1'b0);
                        end
                        else if (pend_reg == CMD_ECHO_MOUSE)
                        begin
                            obuf_next   = v;
                            status_next = obuf_status(status_reg | 8'h0A, 1'b1);
                        end
                        else if (pend_reg[7:5] == GRP_RAM_WRITE)
                        begin
                            if (pend_reg == CMD_WRITE_CFG)
                            begin
                                status_next = ((status_reg | 8'h0A) & 8'hFB) | (v & 8'h04);
                                xlat_next   = v[6];
                            end
                            ram_we    = 1'b1;
                            ram_waddr = pend_reg[4:0];
                        end
                        // password mode stays until a zero byte
                        if (!(pend_reg == CMD_PASS_ENTER && v != 8'h00))
                        begin
                            pend_next = CMD_NONE;
                            mode_next = MODE_KBD;
                        end
                    end
                    default:
                    begin
                        result.send_kbd  = 1'b1;
                        result.send_byte = v;
                    end
                endcase
            end
            FUNC_WRITE_CMD:
            begin
                status_next = (status_reg & 8'hF7) | 8'h02;
                unique case (v[7:5])
                    GRP_RAM_READ:
                    begin
                        obuf_next   = ram_reg[v[4:0]];
                        status_next = obuf_status((status_reg & 8'hF7) | 8'h02, 1'b0);
                    end
                    GRP_RAM_WRITE:
                    begin
                        pend_next = v;
                        mode_next = MODE_COM;
                    end
                    GRP_PORT_LOW:
                    begin
                        if (v[4])
                            outp_next = {outp_reg[7:4], v[3:0]};
                    end
                    GRP_TEST:
                    begin
                        unique case (v)
                            CMD_VERSION:
                            begin
                                obuf_next   = REPLY_VERSION;
                                status_next = obuf_status((status_reg & 8'hF7) | 8'h02, 1'b0);
                            end
                            CMD_PASS_TEST:
                            begin
                                obuf_next   = REPLY_PASS_NONE;
                                status_next = obuf_status((status_reg & 8'hF7) | 8'h02, 1'b0);
                            end
                            CMD_PASS_ENTER:
                            begin
                                pend_next = v;
                                mode_next = MODE_COM;
                            end
                            CMD_MOUSE_OFF:
                            begin
                                ram_we    = 1'b1;
                                ram_wdata = cfg_byte | 8'h20;
                            end
                            CMD_MOUSE_ON:
                            begin
                                ram_we    = 1'b1;
                                ram_wdata = cfg_byte & 8'hDF;
                            end
                            CMD_MOUSE_TEST, CMD_KBD_TEST:
                            begin
                                obuf_next   = REPLY_ZERO;
                                status_next = obuf_status((status_reg & 8'hF7) | 8'h02, 1'b0);
                            end
                            CMD_SELF_TEST:
                            begin
                                obuf_next   = REPLY_SELF_OK;
                                status_next = obuf_status((status_reg & 8'hF7) | 8'h02, 1'b0);
                            end
                            CMD_KBD_OFF:
                            begin
                                ram_we    = 1'b1;
                                ram_wdata = cfg_byte | 8'h10;
                                inp_next  = inp_reg & 8'h7F;
                            end
                            CMD_KBD_ON:
                            begin
                                ram_we    = 1'b1;
                                ram_wdata = cfg_byte & 8'hEF;
                                inp_next  = inp_reg | 8'h80;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    GRP_PORT:
                    begin
                        unique case (v)
                            CMD_READ_INPORT:
                            begin
                                inp_next    = inp_reg | 8'h20;
                                obuf_next   = inp_reg | 8'h20;
                                status_next = obuf_status((status_reg & 8'hF7) | 8'h02, 1'b0);
                            end
                            CMD_POLL_LOW:
                                status_next = {inp_reg[3:0], status_reg[3] & 1'b0,
                                               status_reg[2], 1'b1, status_reg[0]};
                            CMD_POLL_HIGH:
                                status_next = {inp_reg[7:4], status_reg[3] & 1'b0,
                                               status_reg[2], 1'b1, status_reg[0]};
                            CMD_READ_OUTP:
                            begin
                                obuf_next   = outp_reg;
                                status_next = obuf_status((status_reg & 8'hF7) | 8'h02, 1'b0);
                            end
                            CMD_WRITE_OUTP, CMD_ECHO_KBD, CMD_ECHO_MOUSE:
                            begin
                                pend_next = v;
                                mode_next = MODE_COM;
                            end
                            CMD_TO_MOUSE:
                                mode_next = MODE_MOU;
                            default:
                            begin
                            end
                        endcase
                    end
                    GRP_PULSE:
                    begin
                        if (v == CMD_SOFT_RESET)
                        begin
                            pend_next   = CMD_NONE;
                            obuf_next   = REPLY_ZERO;
                            outp_next   = OUT_PORT_RESET;
                            status_next = ((status_reg & 8'hF7) | 8'h02) & 8'hFC;
                            ram_we      = 1'b1;
                            ram_wdata   = 8'h00;
                            mode_next   = MODE_KBD;
                        end
                        else if (v[4])
                            result.reset_request = ~v[0];
                        else if (v == CMD_TEST_INPUTS)
                        begin
                            obuf_next   = REPLY_ZERO;
                            status_next = obuf_status((status_reg & 8'hF7) | 8'h02, 1'b0);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            FUNC_DEVICE:
            begin
                // a device whose clock is disabled keeps its byte unless forced
                if (item.force_req || !(item.from_mouse ? cfg_byte[5] : cfg_byte[4]))
                begin
                    result.device_accepted = 1'b1;
                    obuf_next              = v;
                    status_next            = obuf_status(status_reg, item.from_mouse);
                    result.irq_aux         = item.from_mouse & cfg_byte[1];
                    result.irq_kbd         = ~item.from_mouse;
                end
            end
            default:
            begin
            end
        endcase

        result.output_port  = outp_next;
        result.xt_translate = xlat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= 8'h00;
            obuf_reg   <= 8'h00;
            pend_reg   <= CMD_NONE;
            mode_reg   <= MODE_KBD;
            outp_reg   <= OUT_PORT_RESET;
            inp_reg    <= 8'h00;
            xlat_reg   <= 1'b0;
            for (int i = 0; i < 32; i++)
                ram_reg[i] <= 8'h00;
        end
        else if (step_en)
        begin
            status_reg <= status_next;
            obuf_reg   <= obuf_next;
            pend_reg   <= pend_next;
            mode_reg   <= mode_next;
            outp_reg   <= outp_next;
            inp_reg    <= inp_next;
            xlat_reg   <= xlat_next;
            if (ram_we)
                ram_reg[ram_waddr] <= ram_wdata;
        end
    end

endmodule

// File: dv/ps2_keyboard_controller_test.sv
`timescale 1ns / 1ps

module ps2_keyboard_controller_test;

    import ps2kc_pkg::*;

    // access kinds the controller does not decode
    localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

    // upper nibbles of the port low nibble and pulse command ranges
    localparam logic [3:0] PORT_LOW_SET = 4'h9;
    localparam logic [3:0] PULSE_NIBBLE = 4'hF;

    localparam int RANDOM_ACCESSES = 1300;
    localparam int STALL_LIMIT     = 1000;
    localparam int TAIL_CYCLES     = 10;
    localparam int MAX_REPORTS     = 10;

    // one access plus, where known, the reply read straight off the spec
    typedef struct packed {
        logic [2:0] func;
        logic [7:0] value;
        logic       mouse;
        logic       frc;
        logic       known;
        logic [7:0] rd;
        logic       rv;
        logic [7:0] outp;
        logic       xt;
        logic       acc;
    } access_row_t;

    localparam int N_DIRECTED = 25;

    localparam access_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        // status after reset, then data read with empty buffer
        '{FUNC_READ_STATUS, 8'h00, 1'b0, 1'b0, 1'b1, 8'h10, 1'b1, 8'h02, 1'b0, 1'b0},
        '{FUNC_READ_DATA,   8'hFF, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 8'h02, 1'b0, 1'b0},
        // fixed replies
        '{FUNC_WRITE_CMD, CMD_SELF_TEST, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0, 8'h02, 1'b0, 1'b0},
        '{FUNC_READ_DATA, 8'h00, 1'b0, 1'b0, 1'b1, REPLY_SELF_OK, 1'b1, 8'h02, 1'b0, 1'b0},
        '{FUNC_WRITE_CMD, CMD_VERSION, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0, 8'h02, 1'b0, 1'b0},
        '{FUNC_READ_DATA, 8'h00, 1'b0, 1'b0, 1'b1, REPLY_VERSION, 1'b1, 8'h02, 1'b0, 1'b0},
        // config byte all ones: both clocks off, translation on, mouse irq on
        '{FUNC_WRITE_CMD, CMD_WRITE_CFG, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0, 8'h02, 1'b0, 1'b0},
        '{FUNC_WRITE_DATA, 8'hFF, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0, 8'h02, 1'b1, 1'b0},
        // keyboard byte refused while its clock is off
        '{FUNC_DEVICE, 8'hAB, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0, 8'h02, 1'b1, 1'b0},
        // forced mouse byte, then read it back
        '{FUNC_DEVICE, 8'h00, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
        '{FUNC_READ_DATA, 8'h00, 1'b0, 1'b0, 1'b1, 8'h00, 1'b1, 8'h02, 1'b1, 1'b0},
        '{FUNC_DEVICE, 8'hFF, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
        // output port write with reset bit low, low nibble set, pulse
        '{FUNC_WRITE_CMD, CMD_WRITE_OUTP, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
        '{FUNC_WRITE_DATA, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
        '{FUNC_WRITE_CMD, 8'h9F, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
        '{FUNC_WRITE_CMD, 8'hFE, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
        // forward one byte to the mouse
        '{FUNC_WRITE_CMD, CMD_TO_MOUSE, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
        '{FUNC_WRITE_DATA, 8'h80, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
        // password mode swallows bytes until a zero
        '{FUNC_WRITE_CMD, CMD_PASS_ENTER, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
        '{FUNC_WRITE_DATA, 8'h37, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
        '{FUNC_WRITE_DATA, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
        '{FUNC_WRITE_DATA, 8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
        // soft reset keeps the translation flag
        '{FUNC_WRITE_CMD, CMD_SOFT_RESET, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
        // unused access kinds
        '{FUNC_SPARE_LO, 8'hAA, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
        '{FUNC_SPARE_HI, 8'h55, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0}
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [4:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    ps2_keyboard_controller dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // controller state as the predictor sees it
    logic [7:0] kc_status;
    logic [7:0] kc_obuf;
    logic [7:0] kc_cmd;
    logic [1:0] kc_mode;
    logic [7:0] kc_ram [32];
    logic [7:0] kc_outp;
    logic [7:0] kc_inp;
    logic       kc_xlat;

    access_row_t   access_plan [$];
    ps2kc_result_t due_responses [$];

    int sent_count;
    int checked_count;
    int error_count;
    int workload;
    int n_reads;
    int n_writes;
    int n_device;
    int n_refused;
    int n_pulses;
    int n_spare;
    int sender_idle_pct;
    int receiver_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic bit roll(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic void fill_obuf(logic [7:0] b, logic mouse);
        kc_obuf   = b;
        kc_status = (kc_status & 8'hDE) | 8'h01 | (mouse ? 8'h20 : 8'h00);
    endfunction

    // applies one access to the predicted state and returns its reply
    function automatic ps2kc_result_t controller_response(access_row_t a);
        ps2kc_result_t r;
        logic [7:0]    v;
        logic [7:0]    c;
        logic          keep;
        logic [7:0]    clk_off;
        r    = '0;
        v    = a.value;
        keep = 1'b0;
        case (a.func)
            FUNC_READ_DATA:
            begin
                if (kc_status[0])
                begin
                    r.read_data  = kc_obuf;
                    r.read_valid = 1'b1;
                    kc_status[0] = 1'b0;
                end
            end
            FUNC_READ_STATUS:
            begin
                r.read_data  = kc_status | 8'h10;
                r.read_valid = 1'b1;
                kc_status[1] = 1'b0;
            end
            FUNC_WRITE_DATA:
            begin
                kc_status = kc_status | 8'h0A;
                if (kc_mode == MODE_MOU)
                begin
                    r.send_mouse = 1'b1;
                    r.send_byte  = v;
                    kc_mode      = MODE_KBD;
                end
                else if (kc_mode == MODE_COM)
                begin
                    c = kc_cmd;
                    if (c == CMD_PASS_ENTER)
                        keep = (v != 8'h00);
                    else if (c == CMD_WRITE_OUTP)
                    begin
                        kc_outp         = v;
                        r.reset_request = ~v[0];
                    end
                    else if (c == CMD_ECHO_KBD)
                        fill_obuf(v, 1'b0);
                    else if (c == CMD_ECHO_MOUSE)
                        fill_obuf(v, 1'b1);
                    else if (c[7:5] == GRP_RAM_WRITE)
                    begin
                        if (c == CMD_WRITE_CFG)
                        begin
                            kc_status[2] = v[2];
                            kc_xlat      = v[6];
                        end
                        kc_ram[c[4:0]] = v;
                    end
                    if (!keep)
                    begin
                        kc_cmd  = CMD_NONE;
                        kc_mode = MODE_KBD;
                    end
                end
                else
                begin
                    // keyboard mode, and the unused mode code acts the same
                    r.send_kbd  = 1'b1;
                    r.send_byte = v;
                end
            end
            FUNC_WRITE_CMD:
            begin
                kc_status = (kc_status & 8'hF7) | 8'h02;
                case (v[7:5])
                    GRP_RAM_READ:
                        fill_obuf(kc_ram[v[4:0]], 1'b0);
                    GRP_RAM_WRITE:
                    begin
                        kc_cmd  = v;
                        kc_mode = MODE_COM;
                    end
                    GRP_PORT_LOW:
                    begin
                        if (v[7:4] == PORT_LOW_SET)
                            kc_outp[3:0] = v[3:0];
                    end
                    GRP_TEST:
                    begin
                        case (v)
                            CMD_VERSION:    fill_obuf(REPLY_VERSION, 1'b0);
                            CMD_PASS_TEST:  fill_obuf(REPLY_PASS_NONE, 1'b0);
                            CMD_PASS_ENTER:
                            begin
                                kc_cmd  = v;
                                kc_mode = MODE_COM;
                            end
                            CMD_MOUSE_OFF:  kc_ram[0][5] = 1'b1;
                            CMD_MOUSE_ON:   kc_ram[0][5] = 1'b0;
                            CMD_MOUSE_TEST,
                            CMD_KBD_TEST:   fill_obuf(REPLY_ZERO, 1'b0);
                            CMD_SELF_TEST:  fill_obuf(REPLY_SELF_OK, 1'b0);
                            CMD_KBD_OFF:
                            begin
                                kc_ram[0][4] = 1'b1;
                                kc_inp[7]    = 1'b0;
                            end
                            CMD_KBD_ON:
                            begin
                                kc_ram[0][4] = 1'b0;
                                kc_inp[7]    = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                    GRP_PORT:
                    begin
                        case (v)
                            CMD_READ_INPORT:
                            begin
                                kc_inp[5] = 1'b1;
                                fill_obuf(kc_inp, 1'b0);
                            end
                            CMD_POLL_LOW:   kc_status = {kc_inp[3:0], kc_status[3:0]};
                            CMD_POLL_HIGH:  kc_status = {kc_inp[7:4], kc_status[3:0]};
                            CMD_READ_OUTP:  fill_obuf(kc_outp, 1'b0);
                            CMD_WRITE_OUTP,
                            CMD_ECHO_KBD,
                            CMD_ECHO_MOUSE:
                            begin
                                kc_cmd  = v;
                                kc_mode = MODE_COM;
                            end
                            // pending command number is left alone here
                            CMD_TO_MOUSE:   kc_mode = MODE_MOU;
                            default: ;
                        endcase
                    end
                    GRP_PULSE:
                    begin
                        if (v == CMD_SOFT_RESET)
                        begin
                            kc_cmd       = CMD_NONE;
                            kc_obuf      = 8'h00;
                            kc_outp      = OUT_PORT_RESET;
                            kc_status    = kc_status & 8'hFC;
                            kc_ram[0]    = 8'h00;
                            kc_mode      = MODE_KBD;
                        end
                        else if (v[7:4] == PULSE_NIBBLE)
                            r.reset_request = ~v[0];
                        else if (v == CMD_TEST_INPUTS)
                            fill_obuf(REPLY_ZERO, 1'b0);
                    end
                    default: ;
                endcase
            end
            FUNC_DEVICE:
            begin
                clk_off = a.mouse ? 8'h20 : 8'h10;
                if (a.frc || (kc_ram[0] & clk_off) == 8'h00)
                begin
                    r.device_accepted = 1'b1;
                    fill_obuf(v, a.mouse);
                    if (a.mouse)
                        r.irq_aux = kc_ram[0][1];
                    else
                        r.irq_kbd = 1'b1;
                end
            end
            default: ;
        endcase
        r.output_port  = kc_outp;
        r.xt_translate = kc_xlat;
        return r;
    endfunction

    function automatic string show(ps2kc_result_t r);
        return $sformatf({"rd=%h rv=%b sk=%b sm=%b sb=%h ik=%b im=%b rr=%b ",
                          "op=%h xt=%b acc=%b"},
                         r.read_data, r.read_valid, r.send_kbd, r.send_mouse,
                         r.send_byte, r.irq_kbd, r.irq_aux, r.reset_request,
                         r.output_port, r.xt_translate, r.device_accepted);
    endfunction

    task automatic queue_access(logic [2:0] func, logic [7:0] value, logic mouse,
                                logic frc);
        access_row_t a;
        a       = '0;
        a.func  = func;
        a.value = value;
        a.mouse = mouse;
        a.frc   = frc;
        access_plan.push_back(a);
        if (func <= FUNC_DEVICE)
            workload++;
    endtask

    // builds the random part: mostly complete command sequences
    task automatic plan_random_traffic();
        logic [7:0] c;
        logic [7:0] v;
        int         pick;
        int         n;
        while (workload < RANDOM_ACCESSES)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                case ($urandom_range(0, 25))
                    0:       c = {GRP_RAM_READ, 5'($urandom_range(0, 31))};
                    1, 2:    c = {GRP_RAM_WRITE, 5'($urandom_range(0, 31))};
                    3:       c = CMD_WRITE_CFG;
                    4:       c = {PORT_LOW_SET, 4'($urandom_range(0, 15))};
                    5:       c = CMD_VERSION;
                    6:       c = CMD_PASS_TEST;
                    7:       c = CMD_PASS_ENTER;
                    8:       c = CMD_MOUSE_OFF;
                    9:       c = CMD_MOUSE_ON;
                    10:      c = CMD_MOUSE_TEST;
                    11:      c = CMD_SELF_TEST;
                    12:      c = CMD_KBD_TEST;
                    13:      c = CMD_KBD_OFF;
                    14:      c = CMD_KBD_ON;
                    15:      c = CMD_READ_INPORT;
                    16:      c = CMD_POLL_LOW;
                    17:      c = CMD_POLL_HIGH;
                    18:      c = CMD_READ_OUTP;
                    19:      c = CMD_WRITE_OUTP;
                    20:      c = CMD_ECHO_KBD;
                    21:      c = CMD_ECHO_MOUSE;
                    22:      c = CMD_TO_MOUSE;
                    23:      c = CMD_TEST_INPUTS;
                    24:      c = CMD_SOFT_RESET;
                    default: c = {PULSE_NIBBLE, 4'($urandom_range(0, 14))};
                endcase
                queue_access(FUNC_WRITE_CMD, c, 1'($urandom), 1'($urandom));
                if (c == CMD_PASS_ENTER)
                begin
                    n = $urandom_range(0, 4);
                    repeat (n)
                        queue_access(FUNC_WRITE_DATA, 8'($urandom_range(1, 255)),
                                     1'($urandom), 1'($urandom));
                    queue_access(FUNC_WRITE_DATA, 8'h00, 1'($urandom), 1'($urandom));
                end
                else if (c[7:5] == GRP_RAM_WRITE || c == CMD_WRITE_OUTP ||
                         c == CMD_ECHO_KBD || c == CMD_ECHO_MOUSE || c == CMD_TO_MOUSE)
                begin
                    v = 8'($urandom);
                    // keep device clocks mostly enabled so device bytes get through
                    if (c == CMD_WRITE_CFG && $urandom_range(0, 3) != 0)
                        v[5:4] = 2'b00;
                    queue_access(FUNC_WRITE_DATA, v, 1'($urandom), 1'($urandom));
                end
                if ($urandom_range(0, 1) == 1)
                    queue_access(FUNC_READ_DATA, 8'($urandom), 1'($urandom),
                                 1'($urandom));
            end
            else if (pick < 55)
            begin
                queue_access(FUNC_DEVICE, 8'($urandom), 1'($urandom),
                             $urandom_range(0, 3) == 0);
                if ($urandom_range(0, 1) == 1)
                    queue_access(FUNC_READ_DATA, 8'($urandom), 1'($urandom),
                                 1'($urandom));
            end
            else if (pick < 70)
                queue_access(FUNC_READ_DATA, 8'($urandom), 1'($urandom), 1'($urandom));
            else if (pick < 80)
                queue_access(FUNC_READ_STATUS, 8'($urandom), 1'($urandom), 1'($urandom));
            else if (pick < 90)
                queue_access(FUNC_WRITE_DATA, 8'($urandom), 1'($urandom), 1'($urandom));
            else if (pick < 96)
                queue_access(FUNC_WRITE_CMD, 8'($urandom), 1'($urandom), 1'($urandom));
            else
                queue_access(3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI)),
                             8'($urandom), 1'($urandom), 1'($urandom));
        end
    endtask

    // sender: presents the planned accesses and predicts each transfer
    initial
    begin : feed
        ps2kc_result_t want;
        access_row_t   cur;
        int            phase;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;

        kc_status = 8'h00;
        kc_obuf   = 8'h00;
        kc_cmd    = CMD_NONE;
        kc_mode   = MODE_KBD;
        kc_outp   = OUT_PORT_RESET;
        kc_inp    = 8'h00;
        kc_xlat   = 1'b0;
        for (int i = 0; i < 32; i++)
            kc_ram[i] = 8'h00;

        sent_count = 0;
        workload   = 0;
        for (int i = 0; i < N_DIRECTED; i++)
            access_plan.push_back(DIRECTED_ROWS[i]);
        plan_random_traffic();

        // hold off until reset has been released
        while (rst_n !== 1'b1)
            @(posedge clk);
        while (sent_count < access_plan.size())
        begin
            @(posedge clk);
            if (s_tvalid && s_tready)
            begin
                cur  = access_plan[sent_count];
                want = controller_response(cur);
                if (cur.func == FUNC_READ_DATA || cur.func == FUNC_READ_STATUS)
                    n_reads++;
                else if (cur.func == FUNC_WRITE_DATA || cur.func == FUNC_WRITE_CMD)
                    n_writes++;
                else if (cur.func == FUNC_DEVICE)
                begin
                    n_device++;
                    if (!want.device_accepted)
                        n_refused++;
                end
                else
                    n_spare++;
                if (want.reset_request)
                    n_pulses++;
                // spec-derived reply takes the place of the prediction
                if (cur.known)
                begin
                    want                 = '0;
                    want.read_data       = cur.rd;
                    want.read_valid      = cur.rv;
                    want.output_port     = cur.outp;
                    want.xt_translate    = cur.xt;
                    want.device_accepted = cur.acc;
                end
                due_responses.push_back(want);
                sent_count++;
            end
            phase = (sent_count * 3) / access_plan.size();
            sender_idle_pct   = (phase == 0) ? 9 : (phase == 1) ? 50 : 0;
            receiver_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 9 : 0;
            if (sent_count == access_plan.size())
                s_tvalid <= 1'b0;
            else if (!s_tvalid || s_tready)
            begin
                if (roll(sender_idle_pct))
                    s_tvalid <= 1'b0;
                else
                begin
                    cur = access_plan[sent_count];
                    s_tvalid <= 1'b1;
                    s_tdata  <= cur.value;
                    s_tuser  <= {cur.frc, cur.mouse, cur.func};
                end
            end
        end
    end

    // receiver: random backpressure and in-order checking of each reply
    initial
    begin : drain
        ps2kc_result_t got;
        ps2kc_result_t want;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got = ps2kc_result_t'(m_tdata);
                if (due_responses.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("tb: reply with nothing outstanding: %s", show(got));
                end
                else
                begin
                    want = due_responses.pop_front();
                    checked_count++;
                    if (got.read_data       !== want.read_data       ||
                        got.read_valid      !== want.read_valid      ||
                        got.send_kbd        !== want.send_kbd        ||
                        got.send_mouse      !== want.send_mouse      ||
                        got.send_byte       !== want.send_byte       ||
                        got.irq_kbd         !== want.irq_kbd         ||
                        got.irq_aux         !== want.irq_aux         ||
                        got.reset_request   !== want.reset_request   ||
                        got.output_port     !== want.output_port     ||
                        got.xt_translate    !== want.xt_translate    ||
                        got.device_accepted !== want.device_accepted)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                        begin
                            $display("tb: mismatch on reply %0d", checked_count);
                            $display("    expected %s", show(want));
                            $display("    actual   %s", show(got));
                        end
                    end
                end
            end
            m_tready <= !roll(receiver_idle_pct);
        end
    end

    // reset, watchdog and verdict
    initial
    begin : run
        int idle_cycles;
        error_count       = 0;
        checked_count     = 0;
        n_reads           = 0;
        n_writes          = 0;
        n_device          = 0;
        n_refused         = 0;
        n_pulses          = 0;
        n_spare           = 0;
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        idle_cycles       = 0;
        rst_n <= 1'b0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;

        while (!(sent_count == access_plan.size() && due_responses.size() == 0) &&
               idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end

        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb: no transfer for %0d cycles, %0d of %0d accesses sent,",
                     STALL_LIMIT, sent_count, access_plan.size());
            $display("    %0d replies due", due_responses.size());
            $display("tb: failure");
        end
        else
        begin
            // catch any stray reply after the last expected one
            repeat (TAIL_CYCLES)
                @(posedge clk);
            $display("tb: %0d accesses (%0d reads, %0d writes, %0d device bytes, %0d unused)",
                     sent_count, n_reads, n_writes, n_device, n_spare);
            $display("tb: %0d replies checked, %0d device bytes refused,",
                     checked_count, n_refused);
            $display("    %0d reset pulses, %0d errors", n_pulses, error_count);
            if (error_count == 0)
                $display("tb: success");
            else
                $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: files.f
design/ps2kc_pkg.sv
design/ps2kc_core.sv
design/ps2_keyboard_controller.sv
dv/ps2_keyboard_controller_test.sv
